// ----- rtl/cell_to_tetra_split_macros.svh -----
// Assertion macros for the cell-to-tetrahedra splitter.
// Used by the port checker; no other dependencies.
`ifndef CELL_TO_TETRA_SPLIT_MACROS_SVH
`define CELL_TO_TETRA_SPLIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CTTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ctts check failed");

// Next-cycle implication, sampled on clk, off during reset
`define CTTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ctts check failed");

`endif

// ----- rtl/ctts_pkg.sv -----
// Package for the cell-to-tetrahedra splitter: word types, cell type codes
// and the constant face tables. No dependencies.
package ctts_pkg;

	// Default point id width
	localparam int ID_BITS_DEF = 32;

	// Cell type codes
	localparam logic [1:0] TYPE_PRISM   = 2'd0;
	localparam logic [1:0] TYPE_PYRAMID = 2'd1;
	localparam logic [1:0] TYPE_HEX     = 2'd2;
	localparam logic [1:0] TYPE_BAD     = 2'd3;

	// Input word: one volume cell
	typedef struct packed {
		logic [1:0]  cell_type;
		logic [31:0] corner_0;
		logic [31:0] corner_1;
		logic [31:0] corner_2;
		logic [31:0] corner_3;
		logic [31:0] corner_4;
		logic [31:0] corner_5;
		logic [31:0] corner_6;
		logic [31:0] corner_7;
		logic [31:0] apex_point;
		logic [31:0] region_ref;
	} cell_t;

	// Output word: one tetrahedron
	typedef struct packed {
		logic [31:0] tet_number;
		logic [31:0] tet_a;
		logic [31:0] tet_b;
		logic [31:0] tet_c;
		logic [31:0] tet_d;
		logic [31:0] tet_ref;
		logic        last_of_cell;
		logic        bad_type;
	} tet_t;

	// Corner indices of each boundary face, by cell type and face.
	// The unsupported type has no faces; its row is never walked.
	localparam logic [2:0] FACE_TAB [4][6][4] = '{
		'{ '{3'd0, 3'd2, 3'd1, 3'd0}, '{3'd3, 3'd4, 3'd5, 3'd0},
		   '{3'd0, 3'd1, 3'd4, 3'd3}, '{3'd1, 3'd2, 3'd5, 3'd4},
		   '{3'd2, 3'd0, 3'd3, 3'd5}, '{3'd0, 3'd0, 3'd0, 3'd0} },
		'{ '{3'd0, 3'd3, 3'd2, 3'd1}, '{3'd0, 3'd1, 3'd4, 3'd0},
		   '{3'd1, 3'd2, 3'd4, 3'd0}, '{3'd2, 3'd3, 3'd4, 3'd0},
		   '{3'd3, 3'd0, 3'd4, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0} },
		'{ '{3'd0, 3'd3, 3'd2, 3'd1}, '{3'd4, 3'd5, 3'd6, 3'd7},
		   '{3'd0, 3'd1, 3'd5, 3'd4}, '{3'd1, 3'd2, 3'd6, 3'd5},
		   '{3'd2, 3'd3, 3'd7, 3'd6}, '{3'd3, 3'd0, 3'd4, 3'd7} },
		'{ '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0},
		   '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0},
		   '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0} }
	};

	// Face is a quad (1) or a triangle (0)
	localparam logic FACE_QUAD [4][6] = '{
		'{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}
	};

	// Index of the last face of each cell type
	localparam logic [2:0] FACE_LAST [4] = '{3'd4, 3'd4, 3'd5, 3'd0};

endpackage

// ----- rtl/cell_to_tetra_split.sv -----
// Cell-to-tetrahedra splitter. A cell word is taken when the block is idle;
// the block then raises cell_stall and walks the cell's face table, one face
// step per cycle, producing one tetrahedron word per cycle while the output
// register is free: 8 words for a prism, 6 for a pyramid, 12 for a
// hexahedron, 1 for an unsupported type (a single error word). The next cell
// is taken in the cycle after the last word is loaded. The pace is set by
// the single diagonal compare unit and the single output register, which each
// handle one tetrahedron per cycle; output stalls stretch it one for one.
// Point ids are kept to min(ID_BITS, 32) bits and zero-extended on output.
module cell_to_tetra_split #(
	parameter int ID_BITS = ctts_pkg::ID_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cell_valid,
	output logic           cell_stall,
	input  ctts_pkg::cell_t cell_word,
	output logic           tet_valid,
	input  logic           tet_stall,
	output ctts_pkg::tet_t  tet
);

	localparam int IdW = (ID_BITS < 32) ? ID_BITS : 32;

	// Sequencer control
	logic        busy_q;
	logic [2:0]  face_q;
	logic        half_q;
	logic [31:0] cnt_q;
	logic        tet_valid_q;

	// Cell payload
	logic [1:0]               type_q;
	logic [7:0][IdW-1:0]      corners_q;
	logic [IdW-1:0]           apex_q;
	logic [31:0]              ref_q;
	logic                     flip_q;
	ctts_pkg::tet_t           tet_q;

	// Step logic
	logic [2:0]     sel_a;
	logic [2:0]     sel_b;
	logic [2:0]     sel_c;
	logic [2:0]     sel_d;
	logic [IdW-1:0] id_a;
	logic [IdW-1:0] id_b;
	logic [IdW-1:0] id_c;
	logic [IdW-1:0] id_d;
	logic           ac_lower;
	logic           quad;
	logic           pick_ac;
	logic [IdW-1:0] v1;
	logic [IdW-1:0] v2;
	logic [IdW-1:0] v3;
	logic           face_done;
	logic           last;
	logic           take;
	logic           adv;
	logic [31:0]    cnt_nxt;
	ctts_pkg::tet_t step_word;

	assign cell_stall = busy_q;
	assign tet_valid  = tet_valid_q;
	assign tet        = tet_q;

	assign take    = cell_valid && !busy_q;
	assign adv     = busy_q && (!tet_valid_q || !tet_stall);
	assign cnt_nxt = cnt_q + 32'd1;

	// Fetch the current face's corners
	assign sel_a = ctts_pkg::FACE_TAB[type_q][face_q][0];
	assign sel_b = ctts_pkg::FACE_TAB[type_q][face_q][1];
	assign sel_c = ctts_pkg::FACE_TAB[type_q][face_q][2];
	assign sel_d = ctts_pkg::FACE_TAB[type_q][face_q][3];
	assign id_a  = corners_q[sel_a];
	assign id_b  = corners_q[sel_b];
	assign id_c  = corners_q[sel_c];
	assign id_d  = corners_q[sel_d];

	ctts_diag_cmp #(
		.W(IdW)
	) u_cmp (
		.a    (id_a),
		.b    (id_b),
		.c    (id_c),
		.d    (id_d),
		.lower(ac_lower)
	);

	// Pick the three face vertices of this step's tetrahedron
	always_comb begin
		quad    = ctts_pkg::FACE_QUAD[type_q][face_q];
		pick_ac = half_q ? flip_q : ac_lower;
		if (!quad) begin
			v1 = id_a;
			v2 = id_b;
			v3 = id_c;
		end else if (pick_ac) begin
			v1 = id_a;
			v2 = half_q ? id_c : id_b;
			v3 = half_q ? id_d : id_c;
		end else begin
			v1 = id_b;
			v2 = half_q ? id_d : id_c;
			v3 = half_q ? id_a : id_d;
		end
		face_done = !quad || half_q;
		last      = face_done && (face_q == ctts_pkg::FACE_LAST[type_q]);
	end

	// Build the word for this step
	always_comb begin
		if (type_q == ctts_pkg::TYPE_BAD) begin
			step_word              = '0;
			step_word.last_of_cell = 1'b1;
			step_word.bad_type     = 1'b1;
		end else begin
			step_word.tet_number   = cnt_nxt;
			step_word.tet_a        = 32'(apex_q);
			step_word.tet_b        = 32'(v1);
			step_word.tet_c        = 32'(v2);
			step_word.tet_d        = 32'(v3);
			step_word.tet_ref      = ref_q;
			step_word.last_of_cell = last;
			step_word.bad_type     = 1'b0;
		end
	end

	// Sequencer: take a cell, advance face by face, release on the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			face_q      <= 3'd0;
			half_q      <= 1'b0;
			cnt_q       <= 32'd0;
			tet_valid_q <= 1'b0;
		end else begin
			// Raise valid on a new word, drop it once the word is taken
			if (adv) begin
				tet_valid_q <= 1'b1;
			end else if (!tet_stall) begin
				tet_valid_q <= 1'b0;
			end
			if (take) begin
				busy_q <= 1'b1;
				face_q <= 3'd0;
				half_q <= 1'b0;
			end else if (adv) begin
				if (type_q == ctts_pkg::TYPE_BAD) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_nxt;
					if (last) begin
						busy_q <= 1'b0;
					end else if (face_done) begin
						face_q <= 3'(face_q + 3'd1);
						half_q <= 1'b0;
					end else begin
						half_q <= 1'b1;
					end
				end
			end
		end
	end

	// Hold the cell and the output word
	always_ff @(posedge clk) begin
		if (take) begin
			type_q       <= cell_word.cell_type;
			corners_q[0] <= cell_word.corner_0[IdW-1:0];
			corners_q[1] <= cell_word.corner_1[IdW-1:0];
			corners_q[2] <= cell_word.corner_2[IdW-1:0];
			corners_q[3] <= cell_word.corner_3[IdW-1:0];
			corners_q[4] <= cell_word.corner_4[IdW-1:0];
			corners_q[5] <= cell_word.corner_5[IdW-1:0];
			corners_q[6] <= cell_word.corner_6[IdW-1:0];
			corners_q[7] <= cell_word.corner_7[IdW-1:0];
			apex_q       <= cell_word.apex_point[IdW-1:0];
			ref_q        <= cell_word.region_ref;
		end
		if (adv) begin
			tet_q <= step_word;
			if (!half_q) begin
				flip_q <= ac_lower;
			end
		end
	end

endmodule

// ----- rtl/ctts_diag_cmp.sv -----
// Diagonal compare unit of the cell-to-tetrahedra splitter, shared by all
// quad faces. Standalone; no package use.
module ctts_diag_cmp #(
	parameter int W = 32
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] c,
	input  logic [W-1:0] d,
	output logic         lower
);

	logic [W-1:0] ac_lo;
	logic [W-1:0] ac_hi;
	logic [W-1:0] bd_lo;
	logic [W-1:0] bd_hi;

	// Sort each diagonal, then compare the pairs smaller member first
	always_comb begin
		ac_lo = (a < c) ? a : c;
		ac_hi = (a < c) ? c : a;
		bd_lo = (b < d) ? b : d;
		bd_hi = (b < d) ? d : b;
		lower = (ac_lo < bd_lo) || ((ac_lo == bd_lo) && (ac_hi < bd_hi));
	end

endmodule

// ----- rtl/ctts_checker.sv -----
// Port checker for the cell-to-tetrahedra splitter, bound to the top level.
// Depends on ctts_pkg and the assertion macro header.
`include "cell_to_tetra_split_macros.svh"

module ctts_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cell_valid,
	input logic           cell_stall,
	input logic           tet_valid,
	input logic           tet_stall,
	input ctts_pkg::tet_t  tet
);

	// Stalled output word holds
	`CTTS_ASSERT_NEXT(a_tet_hold, tet_valid && tet_stall, tet_valid && $stable(tet))

	// An error word closes its cell and carries no tetrahedron
	`CTTS_ASSERT_NOW(a_bad_word, tet_valid && tet.bad_type, tet.last_of_cell && (tet.tet_number == 32'd0) && (tet.tet_ref == 32'd0))

	// A taken cell keeps the block busy
	`CTTS_ASSERT_NEXT(a_busy_after_take, cell_valid && !cell_stall, cell_stall)

	// While a word that is not the last is shown, the cell is still in work
	`CTTS_ASSERT_NOW(a_busy_mid_cell, tet_valid && !tet.last_of_cell, cell_stall)

endmodule

bind cell_to_tetra_split ctts_checker u_ctts_checker (.*);

// ----- tb/sv/cell_to_tetra_split_tb.sv -----
`timescale 1ns / 100ps
// Testbench for cell_to_tetra_split: drives cell words, predicts the tetrahedron
// words of each cell and checks every output word field by field.
// Depends on ctts_pkg and the cell_to_tetra_split RTL.
module cell_to_tetra_split_tb;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_CELLS = 380;
	localparam int MAX_PRINTS = 100;

	// Boundary faces per cell kind (prism, pyramid, hexahedron); -1 marks a triangle
	localparam int FACE_N [3] = '{5, 5, 6};
	localparam int FACE_V [3][6][4] = '{
		'{ '{0, 2, 1, -1}, '{3, 4, 5, -1}, '{0, 1, 4, 3}, '{1, 2, 5, 4},
		   '{2, 0, 3, 5}, '{0, 0, 0, -1} },
		'{ '{0, 3, 2, 1}, '{0, 1, 4, -1}, '{1, 2, 4, -1}, '{2, 3, 4, -1},
		   '{3, 0, 4, -1}, '{0, 0, 0, -1} },
		'{ '{0, 3, 2, 1}, '{4, 5, 6, 7}, '{0, 1, 5, 4}, '{1, 2, 6, 5},
		   '{2, 3, 7, 6}, '{3, 0, 4, 7} }
	};

	// Tetrahedron predictor and store of expected output words
	class tetra_board;
		ctts_pkg::tet_t want [$];
		logic [31:0] tet_count;
		int errors;

		function new();
			tet_count = '0;
			errors = 0;
		endfunction

		function int pending();
			return want.size();
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] exp);
			if (errors < MAX_PRINTS)
				$display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, exp);
			errors++;
		endtask

		function void emit(ctts_pkg::cell_t c, logic [31:0] b, logic [31:0] cc,
				logic [31:0] d);
			ctts_pkg::tet_t t;
			tet_count = tet_count + 32'd1;
			t.tet_number = tet_count;
			t.tet_a = c.apex_point;
			t.tet_b = b;
			t.tet_c = cc;
			t.tet_d = d;
			t.tet_ref = c.region_ref;
			t.last_of_cell = 1'b0;
			t.bad_type = 1'b0;
			want.push_back(t);
		endfunction

		// Cone every face of an accepted cell to its apex point; an unsupported cell gives one error word
		function void note_cell(ctts_pkg::cell_t c);
			logic [31:0] v [8];
			logic [31:0] a, b, cc, d, ac_lo, ac_hi, bd_lo, bd_hi;
			ctts_pkg::tet_t t;
			int k, f;
			if (c.cell_type == ctts_pkg::TYPE_BAD) begin
				t = '0;
				t.last_of_cell = 1'b1;
				t.bad_type = 1'b1;
				want.push_back(t);
				return;
			end
			v = '{c.corner_0, c.corner_1, c.corner_2, c.corner_3,
			      c.corner_4, c.corner_5, c.corner_6, c.corner_7};
			k = c.cell_type;
			for (f = 0; f < FACE_N[k]; f++) begin
				a = v[FACE_V[k][f][0]];
				b = v[FACE_V[k][f][1]];
				cc = v[FACE_V[k][f][2]];
				if (FACE_V[k][f][3] < 0) begin
					emit(c, a, b, cc);
				end else begin
					d = v[FACE_V[k][f][3]];
					ac_lo = (a < cc) ? a : cc;
					ac_hi = (a < cc) ? cc : a;
					bd_lo = (b < d) ? b : d;
					bd_hi = (b < d) ? d : b;
					// split along the diagonal with the lower sorted pair
					if (ac_lo < bd_lo || (ac_lo == bd_lo && ac_hi < bd_hi)) begin
						emit(c, a, b, cc);
						emit(c, a, cc, d);
					end else begin
						emit(c, b, cc, d);
						emit(c, b, d, a);
					end
				end
			end
			t = want.pop_back();
			t.last_of_cell = 1'b1;
			want.push_back(t);
		endfunction

		task check_tet(ctts_pkg::tet_t got);
			ctts_pkg::tet_t exp;
			if (want.size() == 0) begin
				report("unexpected word tet_number", got.tet_number, '0);
				return;
			end
			exp = want.pop_front();
			if (got.tet_number !== exp.tet_number)
				report("tet_number", got.tet_number, exp.tet_number);
			if (got.tet_a !== exp.tet_a) report("tet_a", got.tet_a, exp.tet_a);
			if (got.tet_b !== exp.tet_b) report("tet_b", got.tet_b, exp.tet_b);
			if (got.tet_c !== exp.tet_c) report("tet_c", got.tet_c, exp.tet_c);
			if (got.tet_d !== exp.tet_d) report("tet_d", got.tet_d, exp.tet_d);
			if (got.tet_ref !== exp.tet_ref) report("tet_ref", got.tet_ref, exp.tet_ref);
			if (got.last_of_cell !== exp.last_of_cell)
				report("last_of_cell", 32'(got.last_of_cell), 32'(exp.last_of_cell));
			if (got.bad_type !== exp.bad_type)
				report("bad_type", 32'(got.bad_type), 32'(exp.bad_type));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cell_valid = 1'b0;
	logic cell_stall;
	ctts_pkg::cell_t cell_word = '0;
	logic tet_valid;
	logic tet_stall = 1'b0;
	ctts_pkg::tet_t tet;

	tetra_board board;
	bit calm = 1'b0;
	int hold_left = 0;
	int hold_draw;
	int idle_cycles = 0;

	cell_to_tetra_split dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_word  (cell_word),
		.tet_valid  (tet_valid),
		.tet_stall  (tet_stall),
		.tet        (tet)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Wait drawn per word; none at all during calm stretches
	function int idle_draw();
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	// Point id mixing full-range values, near-zero, near-max and single bits
	function logic [31:0] rand_id();
		case ($urandom_range(0, 5))
			3: return 32'($urandom_range(0, 7));
			4: return 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
			5: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function ctts_pkg::cell_t make_cell(logic [1:0] kind, logic [31:0] p [8],
			logic [31:0] apex, logic [31:0] region);
		ctts_pkg::cell_t c;
		c.cell_type = kind;
		c.corner_0 = p[0];
		c.corner_1 = p[1];
		c.corner_2 = p[2];
		c.corner_3 = p[3];
		c.corner_4 = p[4];
		c.corner_5 = p[5];
		c.corner_6 = p[6];
		c.corner_7 = p[7];
		c.apex_point = apex;
		c.region_ref = region;
		return c;
	endfunction

	// Present one cell word after a random gap and hold it until taken
	task automatic send_cell(ctts_pkg::cell_t c);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_word <= c;
		@(posedge clk);
		while (cell_stall) @(posedge clk);
	endtask

	// Extremes per cell kind, then ties on the first quad diagonal
	task automatic run_directed();
		logic [1:0] kinds [4];
		logic [31:0] p [8];
		int t, j;
		kinds = '{ctts_pkg::TYPE_PRISM, ctts_pkg::TYPE_PYRAMID, ctts_pkg::TYPE_HEX,
			ctts_pkg::TYPE_BAD};
		for (t = 0; t < 4; t++) begin
			for (j = 0; j < 8; j++) p[j] = 32'h0;
			send_cell(make_cell(kinds[t], p, 32'h0, 32'h0));
			for (j = 0; j < 8; j++) p[j] = 32'hFFFF_FFFF;
			send_cell(make_cell(kinds[t], p, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
			for (j = 0; j < 8; j++) p[j] = 32'(j + 1);
			send_cell(make_cell(kinds[t], p, 32'hFFFF_FFFF, 32'h0));
			for (j = 0; j < 8; j++) p[j] = 32'hFFFF_FFFF - 32'(j);
			send_cell(make_cell(kinds[t], p, 32'h0, 32'hFFFF_FFFF));
			for (j = 0; j < 8; j++) p[j] = j[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
			send_cell(make_cell(kinds[t], p, 32'h5555_5555, 32'hAAAA_AAAA));
		end
		// face (0,3,2,1): equal low ids, decided by the high ids
		for (t = 1; t < 3; t++) begin
			for (j = 0; j < 8; j++) p[j] = $urandom;
			p[0] = 32'd5; p[3] = 32'd5; p[1] = 32'd7;
			p[2] = 32'd6;
			send_cell(make_cell(kinds[t], p, $urandom, $urandom));
			p[2] = 32'd9;
			send_cell(make_cell(kinds[t], p, $urandom, $urandom));
		end
	endtask

	task automatic run_random();
		logic [1:0] kinds [3];
		logic [31:0] p [8];
		logic [31:0] base;
		bit tight;
		int i, j, r;
		kinds = '{ctts_pkg::TYPE_PRISM, ctts_pkg::TYPE_PYRAMID, ctts_pkg::TYPE_HEX};
		for (i = 0; i < RANDOM_CELLS; i++) begin
			if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			// tight cells draw ids from a narrow window so diagonals tie often
			tight = ($urandom_range(0, 2) == 0);
			base = rand_id();
			for (j = 0; j < 8; j++)
				p[j] = tight ? base + 32'($urandom_range(0, 3)) : rand_id();
			send_cell(make_cell((r < 8) ? ctts_pkg::TYPE_BAD : kinds[r % 3], p,
				rand_id(), rand_id()));
		end
	endtask

	// Score accepted words on both sides
	always @(posedge clk) begin
		if (arst_n) begin
			if (cell_valid && !cell_stall) board.note_cell(cell_word);
			if (tet_valid && !tet_stall) board.check_tet(tet);
		end
	end

	// Stall the output for a drawn number of cycles after each taken word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tet_stall <= 1'b0;
			hold_left <= 0;
		end else if (tet_valid && !tet_stall) begin
			hold_draw = idle_draw();
			hold_left <= hold_draw;
			tet_stall <= (hold_draw != 0);
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			tet_stall <= (hold_left > 1);
		end
	end

	// Drop the run when no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (cell_valid && !cell_stall) || (tet_valid && !tet_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		@(posedge clk);
		cell_valid <= 1'b0;
		// drain outstanding tetrahedra, then watch for stray words
		while (board.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (board.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
